>>> sv/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared constants for the best-fit boundary-tag heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfha_pkg;

  // Heap layout
  localparam int unsigned META_BYTES     = 12;
  localparam int unsigned TAG_BYTES      = 4;
  localparam int unsigned GRAIN          = 8;
  localparam int unsigned BLOCK_OVERHEAD = 8;
  localparam int unsigned PREV_REACH     = 20;
  localparam int unsigned MIN_HEAP       = 32;
  localparam int unsigned RESET_HEAP     = 4096;
  localparam int unsigned DEF_HEAP_BYTES = 4096;

  // Port field widths
  localparam int unsigned CFG_W = 13;
  localparam int unsigned REQ_W = 12;
  localparam int unsigned OFS_W = 12;

  // Operation codes
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

endpackage

`default_nettype wire

>>> sv/best_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit
// Best-fit boundary-tag heap allocator with a sequenced walk over a tag memory.
// ----------------------------------------------------------------------------
// Each walk over the tag memory reads the block tags one at a time, and tag
// writes come between the walks. An allocate makes a best-fit walk and, if it
// places a block, a largest-free rescan; a release makes a search walk and, if
// it frees a block, a rescan. An allocate above the largest free payload, a
// null release or a release below offset 4 finishes without a walk. The cost
// is set by the single read port of the tag memory. After reset or a heap_bytes
// write the unit writes the initial block tags with busy high. A heap_bytes
// write is taken only in a cycle without start.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
`default_nettype none

module best_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_BYTES = bfha_pkg::DEF_HEAP_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_kind,
  input  wire logic [bfha_pkg::REQ_W-1:0]  in_request_size,
  input  wire logic [bfha_pkg::OFS_W-1:0]  in_block_offset,
  output logic                             out_valid,
  output logic                             out_ok,
  output logic [bfha_pkg::OFS_W-1:0]       out_payload_offset,
  output logic [bfha_pkg::OFS_W-1:0]       out_largest_free,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bfha_pkg::CFG_W-1:0]  cfg_heap_bytes
);
  import bfha_pkg::*;

  localparam int unsigned DEPTH = HEAP_BYTES / TAG_BYTES;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned BW    = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned EW    = ((BW > CFG_W) ? BW : CFG_W) + 1;
  localparam int unsigned TOP   = HEAP_BYTES & ~32'd7;
  localparam int unsigned RST_A = (RESET_HEAP < TOP) ? RESET_HEAP : TOP;
  localparam int unsigned RST_HS = (RST_A < MIN_HEAP) ? MIN_HEAP : RST_A;

  localparam logic [EW-1:0] E_META  = EW'(META_BYTES);
  localparam logic [EW-1:0] E_TAG   = EW'(TAG_BYTES);
  localparam logic [EW-1:0] E_GRAIN = EW'(GRAIN);
  localparam logic [EW-1:0] E_OVH   = EW'(BLOCK_OVERHEAD);
  localparam logic [EW-1:0] E_PREV  = EW'(PREV_REACH);
  localparam logic [EW-1:0] E_MIN   = EW'(MIN_HEAP);
  localparam logic [EW-1:0] E_TOP   = EW'(TOP);

  localparam logic [4:0] ST_INIT_H = 5'd0;
  localparam logic [4:0] ST_INIT_F = 5'd1;
  localparam logic [4:0] ST_IDLE   = 5'd2;
  localparam logic [4:0] ST_WRD    = 5'd3;
  localparam logic [4:0] ST_WEV    = 5'd4;
  localparam logic [4:0] ST_WFIN   = 5'd5;
  localparam logic [4:0] ST_A1     = 5'd6;
  localparam logic [4:0] ST_A2     = 5'd7;
  localparam logic [4:0] ST_A3     = 5'd8;
  localparam logic [4:0] ST_A4     = 5'd9;
  localparam logic [4:0] ST_R1     = 5'd10;
  localparam logic [4:0] ST_R2     = 5'd11;
  localparam logic [4:0] ST_RPRD   = 5'd12;
  localparam logic [4:0] ST_RPEV   = 5'd13;
  localparam logic [4:0] ST_RP1    = 5'd14;
  localparam logic [4:0] ST_RP2    = 5'd15;
  localparam logic [4:0] ST_RNRD   = 5'd16;
  localparam logic [4:0] ST_RNEV   = 5'd17;
  localparam logic [4:0] ST_RN1    = 5'd18;
  localparam logic [4:0] ST_RN2    = 5'd19;
  localparam logic [4:0] ST_DONE   = 5'd20;

  localparam logic [1:0] MODE_FIT  = 2'd0;
  localparam logic [1:0] MODE_FIND = 2'd1;
  localparam logic [1:0] MODE_SCAN = 2'd2;

  logic [4:0]    state_r, state_nxt;
  logic [EW-1:0] hs_r, hs_nxt;
  logic [EW-1:0] lf_r, lf_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [EW-1:0] req_r, req_nxt;
  logic [EW-1:0] p_r, p_nxt;
  logic          found_r, found_nxt;
  logic [EW-1:0] bp_r, bp_nxt;
  logic [EW-1:0] bleft_r, bleft_nxt;
  logic [EW-1:0] best_r, best_nxt;
  logic          hit_r, hit_nxt;
  logic [EW-1:0] tgt_r, tgt_nxt;
  logic [EW-1:0] rsz_r, rsz_nxt;
  logic [EW-1:0] h_r, h_nxt;
  logic [EW-1:0] curh_r, curh_nxt;
  logic [EW-1:0] pend_r, pend_nxt;
  logic [EW-1:0] nh_r, nh_nxt;
  logic          ok_r, ok_nxt;
  logic [EW-1:0] pay_r, pay_nxt;

  logic [BW-1:0] tag_mem [DEPTH];
  logic [BW-1:0] mem_q;
  logic [EW-1:0] rd_addr;
  logic          mem_we;
  logic [EW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [EW-1:0] t_val, sz, pay_sz, cfg_hs;
  logic [EW-1:0] rq_round;

  assign t_val  = EW'(mem_q);
  assign sz     = t_val & ~EW'(1);
  assign pay_sz = sz - E_OVH;
  assign rq_round = (EW'(in_request_size) + EW'(7)) & ~EW'(7);

  always_comb begin
    cfg_hs = EW'({cfg_heap_bytes[CFG_W-1:3], 3'b000});
    if (cfg_hs < E_MIN) begin
      cfg_hs = E_MIN;
    end
    if (cfg_hs > E_TOP) begin
      cfg_hs = E_TOP;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !start;
  assign out_valid = (state_r == ST_DONE);
  assign out_ok             = ok_r;
  assign out_payload_offset = pay_r[OFS_W-1:0];
  assign out_largest_free   = lf_r[OFS_W-1:0];

  // Tag memory: one read port, one write port.
  always_comb begin
    unique case (state_r)
      ST_RPRD: rd_addr = tgt_r - E_TAG;
      ST_RNRD: rd_addr = pend_r;
      default: rd_addr = p_r;
    endcase
  end

  always_comb begin
    mem_we  = 1'b1;
    wr_addr = E_META;
    wr_data = hs_r - EW'(16);
    unique case (state_r)
      ST_INIT_H: begin
        wr_addr = E_META;
        wr_data = hs_r - EW'(16);
      end
      ST_INIT_F: begin
        wr_addr = hs_r - E_GRAIN;
        wr_data = hs_r - EW'(16);
      end
      ST_A1: begin
        wr_addr = bp_r;
        wr_data = req_r + E_OVH + EW'(1);
      end
      ST_A2: begin
        wr_addr = bp_r + req_r + E_TAG;
        wr_data = req_r + E_OVH + EW'(1);
      end
      ST_A3: begin
        wr_addr = bp_r + req_r + E_OVH;
        wr_data = bleft_r;
      end
      ST_A4: begin
        wr_addr = bp_r + req_r + E_OVH + bleft_r - E_TAG;
        wr_data = bleft_r;
      end
      ST_R1: begin
        wr_addr = tgt_r;
        wr_data = rsz_r;
      end
      ST_R2: begin
        wr_addr = tgt_r + rsz_r - E_TAG;
        wr_data = rsz_r;
      end
      ST_RP1: begin
        wr_addr = h_r;
        wr_data = curh_r;
      end
      ST_RP2: begin
        wr_addr = pend_r - E_TAG;
        wr_data = curh_r;
      end
      ST_RN1: begin
        wr_addr = h_r;
        wr_data = curh_r;
      end
      ST_RN2: begin
        wr_addr = pend_r + nh_r - E_TAG;
        wr_data = curh_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[wr_addr[IW+1:2]] <= wr_data[BW-1:0];
    end
    mem_q <= tag_mem[rd_addr[IW+1:2]];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    hs_nxt    = hs_r;
    lf_nxt    = lf_r;
    mode_nxt  = mode_r;
    req_nxt   = req_r;
    p_nxt     = p_r;
    found_nxt = found_r;
    bp_nxt    = bp_r;
    bleft_nxt = bleft_r;
    best_nxt  = best_r;
    hit_nxt   = hit_r;
    tgt_nxt   = tgt_r;
    rsz_nxt   = rsz_r;
    h_nxt     = h_r;
    curh_nxt  = curh_r;
    pend_nxt  = pend_r;
    nh_nxt    = nh_r;
    ok_nxt    = ok_r;
    pay_nxt   = pay_r;
    unique case (state_r)
      ST_INIT_H: state_nxt = ST_INIT_F;
      ST_INIT_F: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          ok_nxt  = 1'b0;
          pay_nxt = '0;
          p_nxt   = E_META;
          if (in_kind == KIND_ALLOC) begin
            req_nxt   = rq_round;
            found_nxt = 1'b0;
            bleft_nxt = '0;
            mode_nxt  = MODE_FIT;
            state_nxt = (lf_r < rq_round) ? ST_DONE : ST_WRD;
          end else if (in_block_offset == '0) begin
            ok_nxt    = 1'b1;
            state_nxt = ST_DONE;
          end else if (EW'(in_block_offset) < E_TAG) begin
            state_nxt = ST_DONE;
          end else begin
            tgt_nxt   = EW'(in_block_offset) - E_TAG;
            hit_nxt   = 1'b0;
            mode_nxt  = MODE_FIND;
            state_nxt = ST_WRD;
          end
        end else if (cfg_valid) begin
          hs_nxt    = cfg_hs;
          lf_nxt    = cfg_hs - EW'(24);
          state_nxt = ST_INIT_H;
        end
      end
      ST_WRD: begin
        state_nxt = (p_r + E_GRAIN <= hs_r) ? ST_WEV : ST_WFIN;
      end
      ST_WEV: begin
        if (sz < E_OVH || (p_r + sz) > hs_r) begin
          state_nxt = ST_WFIN;
        end else begin
          state_nxt = ST_WRD;
          p_nxt     = p_r + sz;
          case (mode_r)
            MODE_FIT: begin
              if (!t_val[0] && pay_sz >= req_r) begin
                if (!found_r || (pay_sz - req_r) < bleft_r) begin
                  found_nxt = 1'b1;
                  bp_nxt    = p_r;
                  bleft_nxt = pay_sz - req_r;
                end
              end
            end
            MODE_FIND: begin
              if (p_r == tgt_r) begin
                hit_nxt   = t_val[0];
                rsz_nxt   = sz;
                state_nxt = ST_WFIN;
              end
            end
            default: begin
              if (!t_val[0] && pay_sz > best_r) begin
                best_nxt = pay_sz;
              end
            end
          endcase
        end
      end
      ST_WFIN: begin
        case (mode_r)
          MODE_FIT: begin
            state_nxt = found_r ? ST_A1 : ST_DONE;
          end
          MODE_FIND: begin
            state_nxt = hit_r ? ST_R1 : ST_DONE;
          end
          default: begin
            lf_nxt    = best_r;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_A1: state_nxt = ST_A2;
      ST_A2: begin
        ok_nxt  = 1'b1;
        pay_nxt = bp_r + E_TAG;
        if (bleft_r >= E_GRAIN) begin
          state_nxt = ST_A3;
        end else begin
          p_nxt = E_META; best_nxt = '0; mode_nxt = MODE_SCAN; state_nxt = ST_WRD;
        end
      end
      ST_A3: state_nxt = ST_A4;
      ST_A4: begin
        p_nxt = E_META; best_nxt = '0; mode_nxt = MODE_SCAN; state_nxt = ST_WRD;
      end
      ST_R1: begin
        pend_nxt  = tgt_r + rsz_r;
        h_nxt     = tgt_r;
        curh_nxt  = rsz_r;
        state_nxt = ST_R2;
      end
      ST_R2: begin
        ok_nxt    = 1'b1;
        state_nxt = (tgt_r >= E_PREV) ? ST_RPRD : ST_RNRD;
      end
      ST_RPRD: state_nxt = ST_RPEV;
      ST_RPEV: begin
        // merge with a free previous block found through its footer
        if (!t_val[0] && t_val >= E_OVH && t_val <= tgt_r - E_META) begin
          h_nxt     = tgt_r - t_val;
          curh_nxt  = t_val + rsz_r;
          state_nxt = ST_RP1;
        end else begin
          state_nxt = ST_RNRD;
        end
      end
      ST_RP1: state_nxt = ST_RP2;
      ST_RP2: state_nxt = ST_RNRD;
      ST_RNRD: begin
        if (pend_r + E_GRAIN <= hs_r) begin
          state_nxt = ST_RNEV;
        end else begin
          p_nxt = E_META; best_nxt = '0; mode_nxt = MODE_SCAN; state_nxt = ST_WRD;
        end
      end
      ST_RNEV: begin
        if (!t_val[0] && t_val >= E_OVH && (pend_r + t_val) <= hs_r) begin
          nh_nxt    = t_val;
          curh_nxt  = curh_r + t_val;
          state_nxt = ST_RN1;
        end else begin
          p_nxt = E_META; best_nxt = '0; mode_nxt = MODE_SCAN; state_nxt = ST_WRD;
        end
      end
      ST_RN1: state_nxt = ST_RN2;
      ST_RN2: begin
        p_nxt = E_META; best_nxt = '0; mode_nxt = MODE_SCAN; state_nxt = ST_WRD;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT_H;
      hs_r    <= EW'(RST_HS);
      lf_r    <= EW'(RST_HS) - EW'(24);
    end else begin
      state_r <= state_nxt;
      hs_r    <= hs_nxt;
      lf_r    <= lf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    req_r   <= req_nxt;
    p_r     <= p_nxt;
    found_r <= found_nxt;
    bp_r    <= bp_nxt;
    bleft_r <= bleft_nxt;
    best_r  <= best_nxt;
    hit_r   <= hit_nxt;
    tgt_r   <= tgt_nxt;
    rsz_r   <= rsz_nxt;
    h_r     <= h_nxt;
    curh_r  <= curh_nxt;
    pend_r  <= pend_nxt;
    nh_r    <= nh_nxt;
    ok_r    <= ok_nxt;
    pay_r   <= pay_nxt;
  end

  // Checks
  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_payload_offset == '0))
    else $error("failed operation returned a nonzero offset");

  a_largest_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (lf_r < hs_r))
    else $error("largest free payload exceeds heap size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

`default_nettype wire
